@@ rtl/vwc_pkg.sv @@
// Shared constants, codes and hash helpers for the vocabulary word counter.
// Used by vwc_pending and vocabulary_word_counter_unit; no dependencies.
`default_nettype none
package vwc_pkg;

   localparam int WORD_CHARS = 64;
   localparam int VOCAB_MAX  = 1024;
   localparam int HASH_SIZE  = 4096;

   localparam int CHAR_AW = $clog2(WORD_CHARS);
   localparam int LEN_W   = CHAR_AW + 1;
   localparam int IDX_W   = 10;
   localparam int ENT_W   = 11;
   localparam int BKT_W   = $clog2(HASH_SIZE);
   localparam int VIDX_W  = $clog2(VOCAB_MAX);
   localparam int CHARS_AW = VIDX_W + CHAR_AW;

   localparam logic OP_TEXT = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam logic [7:0] CH_TAB = 8'd9;
   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_CR  = 8'd13;
   localparam logic [7:0] CH_SP  = 8'd32;

   localparam logic [1:0] KIND_FOUND = 2'd0;
   localparam logic [1:0] KIND_ADDED = 2'd1;
   localparam logic [1:0] KIND_FULL  = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   localparam logic [LEN_W-1:0] SENT_LEN = LEN_W'(4);

   function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] v;
      v = {{24{b[7]}}, b};
      return h * 32'd237 + v;
   endfunction

   // Characters of the sentence-end token.
   function automatic logic [7:0] sent_char(input logic [CHAR_AW-1:0] k);
      logic [7:0] c;
      case (k)
         CHAR_AW'(0): c = 8'h3C;
         CHAR_AW'(1): c = 8'h2F;
         CHAR_AW'(2): c = 8'h73;
         CHAR_AW'(3): c = 8'h3E;
         default:     c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [31:0] sent_hash();
      logic [31:0] h;
      h = 32'd0;
      for (int i = 0; i < 4; i++) begin
         h = hash_step(h, sent_char(CHAR_AW'(i)));
      end
      return h;
   endfunction

   localparam logic [31:0]      SENT_HASH   = sent_hash();
   localparam logic [BKT_W-1:0] SENT_BUCKET = SENT_HASH[BKT_W-1:0];

endpackage
`default_nettype wire

@@ rtl/vwc_pending.sv @@
// Buffer for the word being collected: its characters, length and running hash.
// Depends on vwc_pkg.
`default_nettype none
module vwc_pending
   import vwc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire logic [7:0]         push_byte,
   input  wire logic               clear,
   input  wire logic [CHAR_AW-1:0] rd_addr,
   output logic [7:0]              rd_data,
   output logic [LEN_W-1:0]        len,
   output logic [31:0]             hash
);

   logic [7:0]       char_mem [WORD_CHARS];
   logic [LEN_W-1:0] len_ff, len_in;
   logic [31:0]      hash_ff, hash_in;

   always_comb begin
      len_in  = len_ff;
      hash_in = hash_ff;
      if (clear) begin
         len_in  = '0;
         hash_in = '0;
      end else if (push) begin
         len_in  = len_ff + LEN_W'(1);
         hash_in = hash_step(hash_ff, push_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         hash_ff <= '0;
      end else begin
         len_ff  <= len_in;
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !clear) begin
         char_mem[len_ff[CHAR_AW-1:0]] <= push_byte;
      end
      rd_data <= char_mem[rd_addr];
   end

   assign len  = len_ff;
   assign hash = hash_ff;

endmodule
`default_nettype wire

@@ rtl/vocabulary_word_counter_unit.sv @@
// Vocabulary word counter over vwc_pkg and vwc_pending: splits bytes into words, counts them.
// A plain byte is taken one per cycle while idle. A word end leaves idle for the bucket read,
// then probes entries (cache first, then a scan on a miss) character by character until one
// matches or all fail; on a miss it checks for room and copies a new word, then loads the result.
// One word at a time; a newline after a word runs two tokens; a result waits for rsp_ready.
// After reset a clearing pass over all HASH_SIZE (4096) buckets sets them up, req_ready low.
`default_nettype none
module vocabulary_word_counter_unit
   import vwc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic         req_op,
   input  wire logic [7:0]   req_text_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [IDX_W-1:0]  rsp_word_index,
   output logic [31:0]       rsp_word_count,
   output logic [ENT_W-1:0]  rsp_vocab_entries,
   output logic [31:0]       rsp_total_tokens,
   output logic              rsp_last
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_LOOK  = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_MISS  = 3'd4;
   localparam logic [2:0] S_COPY  = 3'd5;
   localparam logic [2:0] S_RES   = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [BKT_W-1:0]   clr_ff, clr_in;
   logic [BKT_W-1:0]   btok_ff, btok_in;
   logic [VIDX_W-1:0]  cidx_ff, cidx_in;
   logic [CHAR_AW-1:0] k_ff, k_in;
   logic [LEN_W-1:0]   wlen_ff, wlen_in;
   logic               sent_ff, sent_in;
   logic               scan_ff, scan_in;
   logic               then_ff, then_in;
   logic               last_ff, last_in;
   logic [ENT_W-1:0]   entries_ff, entries_in;
   logic [31:0]        total_ff, total_in;
   logic [1:0]         rkind_ff, rkind_in;
   logic [IDX_W-1:0]   ridx_ff, ridx_in;
   logic [31:0]        rcnt_ff, rcnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff;
   logic [IDX_W-1:0]   rsp_index_ff;
   logic [31:0]        rsp_count_ff;
   logic [ENT_W-1:0]   rsp_entries_ff;
   logic [31:0]        rsp_total_ff;
   logic               rsp_last_ff;
   logic               load;

   // Vocabulary storage and the bucket cache (valid bit over entry index).
   logic [7:0]         chars_mem [VOCAB_MAX*WORD_CHARS];
   logic [LEN_W-1:0]   len_mem   [VOCAB_MAX];
   logic [31:0]        cnt_mem   [VOCAB_MAX];
   logic [VIDX_W:0]    bkt_mem   [HASH_SIZE];
   logic [7:0]         chars_rd;
   logic [LEN_W-1:0]   len_rd;
   logic [31:0]        cnt_rd;
   logic [VIDX_W:0]    bkt_rd;

   logic               ch_we, len_we, cnt_we, bkt_we;
   logic [CHARS_AW-1:0] ch_wa;
   logic [7:0]         ch_wd;
   logic [VIDX_W-1:0]  len_wa, cnt_wa;
   logic [LEN_W-1:0]   len_wd;
   logic [31:0]        cnt_wd;
   logic [BKT_W-1:0]   bkt_wa;
   logic [VIDX_W:0]    bkt_wd;

   logic               pd_push, pd_clear;
   logic [7:0]         pd_rd;
   logic [LEN_W-1:0]   pd_len;
   logic [31:0]        pd_hash;

   logic               accept, out_free, tok_go, tok_sent;
   logic [7:0]         src_char;
   logic [31:0]        new_cnt;
   logic [ENT_W-1:0]   next_cidx;

   vwc_pending u_pending (
      .clock     (clock),
      .reset     (reset),
      .push      (pd_push),
      .push_byte (req_text_byte),
      .clear     (pd_clear),
      .rd_addr   (k_in),
      .rd_data   (pd_rd),
      .len       (pd_len),
      .hash      (pd_hash)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign src_char  = sent_ff ? sent_char(k_ff) : pd_rd;
   assign new_cnt   = (cnt_rd == 32'hFFFF_FFFF) ? cnt_rd : cnt_rd + 32'd1;
   assign next_cidx = {1'b0, cidx_ff} + ENT_W'(1);

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      btok_in    = btok_ff;
      cidx_in    = cidx_ff;
      k_in       = k_ff;
      wlen_in    = wlen_ff;
      sent_in    = sent_ff;
      scan_in    = scan_ff;
      then_in    = then_ff;
      last_in    = last_ff;
      entries_in = entries_ff;
      total_in   = total_ff;
      rkind_in   = rkind_ff;
      ridx_in    = ridx_ff;
      rcnt_in    = rcnt_ff;
      load       = 1'b0;
      pd_push    = 1'b0;
      pd_clear   = 1'b0;
      tok_go     = 1'b0;
      tok_sent   = 1'b0;
      ch_we  = 1'b0; ch_wa  = '0; ch_wd  = '0;
      len_we = 1'b0; len_wa = '0; len_wd = '0;
      cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0;
      bkt_we = 1'b0; bkt_wa = '0; bkt_wd = '0;

      case (state_ff)
         S_CLEAR: begin
            // Empty every bucket and plant the sentence-end token at entry 0.
            bkt_we = 1'b1;
            bkt_wa = clr_ff;
            bkt_wd = (clr_ff == SENT_BUCKET) ? {1'b1, VIDX_W'(0)} : '0;
            if (clr_ff < BKT_W'(4)) begin
               ch_we = 1'b1;
               ch_wa = {VIDX_W'(0), clr_ff[CHAR_AW-1:0]};
               ch_wd = sent_char(clr_ff[CHAR_AW-1:0]);
            end
            if (clr_ff == '0) begin
               len_we = 1'b1; len_wa = '0; len_wd = SENT_LEN;
               cnt_we = 1'b1; cnt_wa = '0; cnt_wd = '0;
            end
            clr_in = clr_ff + BKT_W'(1);
            if (clr_ff == BKT_W'(HASH_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_END) begin
                  pd_clear = 1'b1;
                  rkind_in = KIND_END;
                  ridx_in  = '0;
                  rcnt_in  = '0;
                  last_in  = 1'b1;
                  then_in  = 1'b0;
                  state_in = S_RES;
               end else begin
                  case (req_text_byte)
                     CH_CR: begin
                     end
                     CH_SP, CH_TAB: begin
                        if (pd_len != '0) begin
                           tok_go  = 1'b1;
                           last_in = 1'b1;
                           then_in = 1'b0;
                        end
                     end
                     CH_LF: begin
                        tok_go = 1'b1;
                        if (pd_len != '0) begin
                           last_in = 1'b0;
                           then_in = 1'b1;
                        end else begin
                           tok_sent = 1'b1;
                           last_in  = 1'b1;
                           then_in  = 1'b0;
                        end
                     end
                     default: begin
                        if (pd_len < LEN_W'(WORD_CHARS - 1)) begin
                           pd_push = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         S_LOOK: begin
            k_in = '0;
            if (bkt_rd[VIDX_W] && ({1'b0, bkt_rd[VIDX_W-1:0]} < entries_ff)) begin
               cidx_in  = bkt_rd[VIDX_W-1:0];
               scan_in  = 1'b0;
               state_in = S_CMP;
            end else if (bkt_rd[VIDX_W]) begin
               cidx_in  = '0;
               scan_in  = 1'b1;
               state_in = S_CMP;
            end else begin
               state_in = S_MISS;
            end
         end
         S_CMP: begin
            // Length and character k of entry cidx arrive each cycle.
            if (len_rd == wlen_ff && {1'b0, k_ff} == wlen_ff) begin
               cnt_we = 1'b1; cnt_wa = cidx_ff; cnt_wd = new_cnt;
               if (scan_ff) begin
                  bkt_we = 1'b1; bkt_wa = btok_ff; bkt_wd = {1'b1, cidx_ff};
               end
               rkind_in = KIND_FOUND;
               ridx_in  = IDX_W'(cidx_ff);
               rcnt_in  = new_cnt;
               state_in = S_RES;
            end else if (len_rd == wlen_ff && chars_rd == src_char) begin
               k_in = k_ff + CHAR_AW'(1);
            end else begin
               k_in = '0;
               if (!scan_ff) begin
                  cidx_in = '0;
                  scan_in = 1'b1;
               end else if (next_cidx < entries_ff) begin
                  cidx_in = next_cidx[VIDX_W-1:0];
               end else begin
                  state_in = S_MISS;
               end
            end
         end
         S_MISS: begin
            k_in = '0;
            if (entries_ff >= ENT_W'(VOCAB_MAX)) begin
               rkind_in = KIND_FULL;
               ridx_in  = '0;
               rcnt_in  = '0;
               state_in = S_RES;
            end else begin
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            ch_we = 1'b1;
            ch_wa = {entries_ff[VIDX_W-1:0], k_ff};
            ch_wd = src_char;
            if ({1'b0, k_ff} + LEN_W'(1) == wlen_ff) begin
               len_we = 1'b1; len_wa = entries_ff[VIDX_W-1:0]; len_wd = wlen_ff;
               cnt_we = 1'b1; cnt_wa = entries_ff[VIDX_W-1:0]; cnt_wd = 32'd1;
               bkt_we = 1'b1; bkt_wa = btok_ff; bkt_wd = {1'b1, entries_ff[VIDX_W-1:0]};
               entries_in = entries_ff + ENT_W'(1);
               rkind_in   = KIND_ADDED;
               ridx_in    = IDX_W'(entries_ff[VIDX_W-1:0]);
               rcnt_in    = 32'd1;
               state_in   = S_RES;
            end else begin
               k_in = k_ff + CHAR_AW'(1);
            end
         end
         S_RES: begin
            if (out_free) begin
               load = 1'b1;
               if (then_ff) begin
                  tok_go   = 1'b1;
                  tok_sent = 1'b1;
                  then_in  = 1'b0;
                  last_in  = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Start of a token: bucket lookup is issued now, data arrives in S_LOOK.
      if (tok_go) begin
         sent_in  = tok_sent;
         btok_in  = tok_sent ? SENT_BUCKET : pd_hash[BKT_W-1:0];
         wlen_in  = tok_sent ? SENT_LEN : pd_len;
         total_in = (total_ff == 32'hFFFF_FFFF) ? total_ff : total_ff + 32'd1;
         k_in     = '0;
         state_in = S_LOOK;
         if (!tok_sent) begin
            pd_clear = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         entries_ff <= ENT_W'(1);
         total_ff   <= '0;
         then_ff    <= 1'b0;
         k_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         entries_ff <= entries_in;
         total_ff   <= total_in;
         then_ff    <= then_in;
         k_ff       <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      btok_ff  <= btok_in;
      cidx_ff  <= cidx_in;
      wlen_ff  <= wlen_in;
      sent_ff  <= sent_in;
      scan_ff  <= scan_in;
      last_ff  <= last_in;
      rkind_ff <= rkind_in;
      ridx_ff  <= ridx_in;
      rcnt_ff  <= rcnt_in;
   end

   always_ff @(posedge clock) begin
      if (ch_we) begin
         chars_mem[ch_wa] <= ch_wd;
      end
      chars_rd <= chars_mem[{cidx_in, k_in}];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_wa] <= len_wd;
      end
      len_rd <= len_mem[cidx_in];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      cnt_rd <= cnt_mem[cidx_in];
   end

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bkt_mem[bkt_wa] <= bkt_wd;
      end
      bkt_rd <= bkt_mem[btok_in];
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_kind_ff    <= rkind_ff;
         rsp_index_ff   <= ridx_ff;
         rsp_count_ff   <= rcnt_ff;
         rsp_entries_ff <= entries_ff;
         rsp_total_ff   <= total_ff;
         rsp_last_ff    <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_word_index    = rsp_index_ff;
   assign rsp_word_count    = rsp_count_ff;
   assign rsp_vocab_entries = rsp_entries_ff;
   assign rsp_total_tokens  = rsp_total_ff;
   assign rsp_last          = rsp_last_ff;

endmodule
`default_nettype wire

@@ dv/vocabulary_word_counter_unit_tb.sv @@
// Self-checking testbench for vocabulary_word_counter_unit: a directed table, then random
// text under three idling mixes; results are checked by a local model.
// Depends on rtl/vwc_pkg.sv and the RTL of vocabulary_word_counter_unit.
`default_nettype none
module vocabulary_word_counter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vwc_pkg::*;

   typedef struct {
      logic [1:0]       kind;
      logic [IDX_W-1:0] idx;
      logic [31:0]      cnt;
      logic [ENT_W-1:0] ents;
      logic [31:0]      tot;
      logic             last;
   } token_rsp_type;

   typedef struct {
      logic          op;
      logic [7:0]    ch;
      bit            typed;
      token_rsp_type rsp;
   } text_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_op = OP_TEXT;
   logic [7:0]       req_text_byte = 8'd0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [1:0]       rsp_kind;
   logic [IDX_W-1:0] rsp_word_index;
   logic [31:0]      rsp_word_count;
   logic [ENT_W-1:0] rsp_vocab_entries;
   logic [31:0]      rsp_total_tokens;
   logic             rsp_last;

   vocabulary_word_counter_unit DUT (.*);

   // Local copy of the vocabulary and the word being collected.
   logic [7:0]  vocab_chars [VOCAB_MAX][WORD_CHARS];
   int          vocab_len [VOCAB_MAX];
   logic [31:0] vocab_cnt [VOCAB_MAX];
   int          bucket_idx [HASH_SIZE];
   bit          bucket_ok [HASH_SIZE];
   int          vocab_used;
   logic [7:0]  word_buf [WORD_CHARS];
   logic [7:0]  sent_buf [WORD_CHARS];
   int          word_len;
   logic [31:0] word_hash;
   logic [31:0] sent_hash_val;
   logic [31:0] tokens_seen;

   token_rsp_type rsp_expected[$];
   text_row_type  text_rows[$];
   int            errors = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [31:0] mix(input logic [31:0] h, input logic [7:0] c);
      return h * 32'd237 + {{24{c[7]}}, c};
   endfunction

   function automatic bit word_matches(input int e, input logic [7:0] w [WORD_CHARS],
                                       input int n);
      if (vocab_len[e] != n) return 1'b0;
      for (int i = 0; i < n; i++)
         if (vocab_chars[e][i] !== w[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void vocab_reset();
      for (int b = 0; b < HASH_SIZE; b++) bucket_ok[b] = 1'b0;
      sent_buf[0] = "<";
      sent_buf[1] = "/";
      sent_buf[2] = "s";
      sent_buf[3] = ">";
      sent_hash_val = 32'd0;
      for (int i = 0; i < 4; i++) sent_hash_val = mix(sent_hash_val, sent_buf[i]);
      for (int i = 0; i < 4; i++) vocab_chars[0][i] = sent_buf[i];
      vocab_len[0] = 4;
      vocab_cnt[0] = 32'd0;
      bucket_idx[sent_hash_val[BKT_W-1:0]] = 0;
      bucket_ok[sent_hash_val[BKT_W-1:0]] = 1'b1;
      vocab_used = 1;
      word_len = 0;
      word_hash = 32'd0;
      tokens_seen = 32'd0;
   endfunction

   function automatic void tally(input logic [7:0] w [WORD_CHARS], input int n,
                                 input logic [31:0] h, input bit last);
      logic [BKT_W-1:0] b;
      token_rsp_type    r;
      int               hit_idx;
      b = h[BKT_W-1:0];
      hit_idx = -1;
      if (tokens_seen != 32'hFFFF_FFFF) tokens_seen++;
      if (bucket_ok[b]) begin
         if (bucket_idx[b] < vocab_used && word_matches(bucket_idx[b], w, n)) begin
            hit_idx = bucket_idx[b];
         end else begin
            for (int e = 0; e < vocab_used; e++) begin
               if (word_matches(e, w, n)) begin
                  hit_idx = e;
                  bucket_idx[b] = e;
                  break;
               end
            end
         end
      end
      if (hit_idx >= 0) begin
         if (vocab_cnt[hit_idx] != 32'hFFFF_FFFF) vocab_cnt[hit_idx]++;
         r.kind = KIND_FOUND;
         r.idx  = IDX_W'(hit_idx);
         r.cnt  = vocab_cnt[hit_idx];
      end else if (vocab_used >= VOCAB_MAX) begin
         r.kind = KIND_FULL;
         r.idx  = '0;
         r.cnt  = 32'd0;
      end else begin
         for (int i = 0; i < n; i++) vocab_chars[vocab_used][i] = w[i];
         vocab_len[vocab_used] = n;
         vocab_cnt[vocab_used] = 32'd1;
         bucket_idx[b] = vocab_used;
         bucket_ok[b] = 1'b1;
         r.kind = KIND_ADDED;
         r.idx  = IDX_W'(vocab_used);
         r.cnt  = 32'd1;
         vocab_used++;
      end
      r.ents = ENT_W'(vocab_used);
      r.tot  = tokens_seen;
      r.last = last;
      rsp_expected.push_back(r);
   endfunction

   function automatic void predict_text(input logic op, input logic [7:0] c);
      token_rsp_type r;
      if (op == OP_END) begin
         word_len = 0;
         word_hash = 32'd0;
         r.kind = KIND_END;
         r.idx  = '0;
         r.cnt  = 32'd0;
         r.ents = ENT_W'(vocab_used);
         r.tot  = tokens_seen;
         r.last = 1'b1;
         rsp_expected.push_back(r);
      end else if (c == CH_CR) begin
      end else if (c == CH_SP || c == CH_TAB) begin
         if (word_len != 0) tally(word_buf, word_len, word_hash, 1'b1);
         word_len = 0;
         word_hash = 32'd0;
      end else if (c == CH_LF) begin
         if (word_len != 0) tally(word_buf, word_len, word_hash, 1'b0);
         word_len = 0;
         word_hash = 32'd0;
         tally(sent_buf, 4, sent_hash_val, 1'b1);
      end else if (word_len < WORD_CHARS - 1) begin
         word_buf[word_len] = c;
         word_len++;
         word_hash = mix(word_hash, c);
      end
   endfunction

   task automatic send_text(input logic op, input logic [7:0] c);
      // The sender idles cycle by cycle at the set rate.
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_text_byte <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_text(op, c);
   endtask

   task automatic send_random_word(input int letters);
      int n;
      int pick;
      logic [7:0] sep;
      n = ($urandom_range(99) < 4) ? $urandom_range(70, 60) : $urandom_range(5, 1);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 8) send_text(OP_TEXT, 8'($urandom_range(255)));
         else send_text(OP_TEXT, 8'("a" + $urandom_range(letters - 1)));
      end
      pick = $urandom_range(99);
      if (pick < 45)      sep = CH_SP;
      else if (pick < 65) sep = CH_TAB;
      else if (pick < 85) sep = CH_LF;
      else if (pick < 93) sep = CH_CR;
      else                sep = 8'h00;
      if ($urandom_range(99) < 3) send_text(OP_END, 8'($urandom_range(255)));
      else send_text(OP_TEXT, sep);
   endtask

   function automatic void add_row(input logic op, input logic [7:0] c, input bit typed,
                                   input logic [1:0] kind, input int idx, input int cnt,
                                   input int ents, input int tot);
      text_row_type row;
      row.op = op;
      row.ch = c;
      row.typed = typed;
      row.rsp.kind = kind;
      row.rsp.idx  = IDX_W'(idx);
      row.rsp.cnt  = 32'(cnt);
      row.rsp.ents = ENT_W'(ents);
      row.rsp.tot  = 32'(tot);
      row.rsp.last = 1'b1;
      text_rows.push_back(row);
   endfunction

   always @(posedge clock) begin
      token_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_expected.size() == 0) begin
            $error("word result with nothing expected: kind %0d", rsp_kind);
            errors++;
         end else begin
            want = rsp_expected.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               errors++;
            end
            if (rsp_word_index !== want.idx) begin
               $error("word_index: expected %0d, got %0d", want.idx, rsp_word_index);
               errors++;
            end
            if (rsp_word_count !== want.cnt) begin
               $error("word_count: expected %0d, got %0d", want.cnt, rsp_word_count);
               errors++;
            end
            if (rsp_vocab_entries !== want.ents) begin
               $error("vocab_entries: expected %0d, got %0d", want.ents, rsp_vocab_entries);
               errors++;
            end
            if (rsp_total_tokens !== want.tot) begin
               $error("total_tokens: expected %0d, got %0d", want.tot, rsp_total_tokens);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   initial begin
      vocab_reset();
      add_row(OP_TEXT, CH_LF, 1, KIND_FOUND, 0, 1, 1, 1);
      add_row(OP_END, 8'hFF, 1, KIND_END, 0, 0, 1, 1);
      add_row(OP_TEXT, "a", 0, KIND_FOUND, 0, 0, 0, 0);
      add_row(OP_TEXT, CH_SP, 1, KIND_ADDED, 1, 1, 2, 2);
      add_row(OP_TEXT, CH_CR, 0, KIND_FOUND, 0, 0, 0, 0);
      add_row(OP_TEXT, CH_SP, 0, KIND_FOUND, 0, 0, 0, 0);
      add_row(OP_TEXT, CH_TAB, 0, KIND_FOUND, 0, 0, 0, 0);
      add_row(OP_TEXT, "a", 0, KIND_FOUND, 0, 0, 0, 0);
      add_row(OP_TEXT, CH_TAB, 1, KIND_FOUND, 1, 2, 2, 3);
      add_row(OP_TEXT, 8'h00, 0, KIND_FOUND, 0, 0, 0, 0);
      add_row(OP_TEXT, 8'hFF, 0, KIND_FOUND, 0, 0, 0, 0);
      add_row(OP_TEXT, 8'h80, 0, KIND_FOUND, 0, 0, 0, 0);
      add_row(OP_TEXT, 8'h7F, 0, KIND_FOUND, 0, 0, 0, 0);
      add_row(OP_TEXT, CH_LF, 0, KIND_FOUND, 0, 0, 0, 0);
      add_row(OP_TEXT, "b", 0, KIND_FOUND, 0, 0, 0, 0);
      add_row(OP_END, 8'h00, 1, KIND_END, 0, 0, 3, 5);
      add_row(OP_TEXT, "<", 0, KIND_FOUND, 0, 0, 0, 0);
      add_row(OP_TEXT, "/", 0, KIND_FOUND, 0, 0, 0, 0);
      add_row(OP_TEXT, "s", 0, KIND_FOUND, 0, 0, 0, 0);
      add_row(OP_TEXT, ">", 0, KIND_FOUND, 0, 0, 0, 0);
      add_row(OP_TEXT, CH_SP, 0, KIND_FOUND, 0, 0, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (text_rows[i]) begin
         send_text(text_rows[i].op, text_rows[i].ch);
         if (text_rows[i].typed) begin
            void'(rsp_expected.pop_back());
            rsp_expected.push_back(text_rows[i].rsp);
         end
      end
      // A word longer than the store keeps only its first characters.
      for (int i = 0; i < WORD_CHARS + 6; i++) send_text(OP_TEXT, 8'("x" + (i % 2)));
      send_text(OP_TEXT, CH_SP);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 69 : 0;
         recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 30 : 0;
         for (int w = 0; w < 60; w++) send_random_word((phase == 2) ? 6 : 4);
      end

      send_text(OP_END, 8'h00);
      req_valid <= 1'b0;

      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
